[rtl/core/binned_pair_probability_core_assert.svh]
// Assertion macros shared by the checkers of the binned pair probability core.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BINNED_PAIR_PROBABILITY_CORE_ASSERT_SVH
`define BINNED_PAIR_PROBABILITY_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BPP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bpp_pkg.sv]
// Package for the binned pair probability core: sizes, codes, item types and
// the binning and saturating-count helpers. No dependencies.
`timescale 1ns / 1ps

package bpp_pkg;

  localparam int NUM_EFF_LEVELS = 7;
  localparam int NUM_LEN_LEVELS = 6;
  localparam int NUM_BINS       = NUM_EFF_LEVELS * NUM_LEN_LEVELS;
  localparam int BIN_W          = $clog2(NUM_BINS);
  localparam int EFF_LVL_W      = $clog2(NUM_EFF_LEVELS);
  localparam int LEN_LVL_W      = $clog2(NUM_LEN_LEVELS);

  localparam int EFF_W    = 10;
  localparam int LEN_W    = 16;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 32;
  localparam int PROD_W   = 2 * CNT_W;
  localparam int PROB_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(64'h8000_0000);

  // Quotient bits produced for a pair of distinct bins and for a diagonal bin.
  localparam int DIV_STEPS_PAIR = PROB_W;
  localparam int DIV_STEPS_SAME = PROB_W - 1;
  localparam int STEP_W         = $clog2(DIV_STEPS_PAIR + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Effective-value thresholds are odd multiples of 16 starting at 3*16.
  localparam int EFF_THR_BASE = 3;
  localparam int EFF_THR_STEP = 2;
  localparam int EFF_FRAC     = 16;

  localparam logic [LEN_W-1:0] LEN_THR [0:NUM_LEN_LEVELS-2] =
    '{16'd75, 16'd150, 16'd300, 16'd500, 16'd700};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  // Classified transaction as it sits in the queue; for an add, row is the bin.
  typedef struct packed {
    logic             is_query;
    logic             bad;
    logic [BIN_W-1:0] row;
    logic [BIN_W-1:0] col;
  } item_t;

  typedef struct packed {
    logic [PROD_W-1:0] num;
    logic [PROD_W-1:0] den;
    logic              dbl;
  } div_req_t;

  function automatic logic [BIN_W-1:0] bin_of(input logic [EFF_W-1:0] eff,
                                              input logic [LEN_W-1:0] len);
    logic [EFF_LVL_W-1:0] e;
    logic [LEN_LVL_W-1:0] l;
    e = '0;
    l = '0;
    for (int k = 0; k < NUM_EFF_LEVELS - 1; k++) begin
      if (eff >= EFF_W'((EFF_THR_STEP * k + EFF_THR_BASE) * EFF_FRAC)) begin
        e = e + 1'b1;
      end
    end
    for (int k = 0; k < NUM_LEN_LEVELS - 1; k++) begin
      if (len >= LEN_THR[k]) begin
        l = l + 1'b1;
      end
    end
    return BIN_W'(BIN_W'(e) * BIN_W'(NUM_LEN_LEVELS)) + BIN_W'(l);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

endpackage

[rtl/core/bpp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 42
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/bpp_div.sv]
// Restoring fraction divider: floor(num * 2^s / den) saturated at 1.0 in Q1.31,
// one quotient bit per cycle. Depends on bpp_pkg.
`timescale 1ns / 1ps

module bpp_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  bpp_pkg::div_req_t        req,
  output logic                     done,
  output logic [bpp_pkg::PROB_W-1:0] quo
);
  import bpp_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;
  logic [PROD_W-1:0]   rem_r, rem_nxt;
  logic [PROD_W-1:0]   den_r, den_nxt;
  logic [PROB_W-1:0]   quo_r, quo_nxt;
  logic [PROD_W:0]     rem2;
  logic                ge;

  assign rem2 = {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, den_r};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    steps_nxt = steps_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    quo_nxt   = quo_r;
    if (start) begin
      den_nxt = req.den;
      rem_nxt = req.num;
      if (req.num >= req.den) begin
        // Integer part is at least one, so the scaled value is at least 1.0.
        quo_nxt  = PROB_ONE;
        done_nxt = 1'b1;
      end else begin
        quo_nxt   = '0;
        steps_nxt = req.dbl ? STEP_W'(DIV_STEPS_PAIR) : STEP_W'(DIV_STEPS_SAME);
        busy_nxt  = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt   = ge ? PROD_W'(rem2 - {1'b0, den_r}) : PROD_W'(rem2);
      quo_nxt   = {quo_r[PROB_W-2:0], ge};
      steps_nxt = steps_r - 1'b1;
      if (steps_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    steps_r <= steps_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    quo_r   <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = (quo_r > PROB_ONE) ? PROB_ONE : quo_r;

endmodule

[rtl/core/bpp_back.sv]
// Back end: sequencer over the bin counter RAM, the total, the multipliers,
// the divider and the output register. Depends on bpp_pkg, bpp_ram, bpp_div.
`timescale 1ns / 1ps

module bpp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  bpp_pkg::item_t                q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bpp_pkg::PROB_W-1:0]    out_prob,
  output logic [bpp_pkg::STATUS_W-1:0]  out_status
);
  import bpp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_ADD_WR  = 9'b000000010,
    S_Q_COL   = 9'b000000100,
    S_Q_MUL   = 9'b000001000,
    S_Q_START = 9'b000010000,
    S_Q_DIV   = 9'b000100000,
    S_EMIT    = 9'b001000000,
    S_SPARE_A = 9'b010000000,
    S_SPARE_B = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [NUM_BINS-1:0] valid_r, valid_nxt;
  logic                rd_valid_r, rd_valid_nxt;
  logic [BIN_W-1:0]    bin_r, bin_nxt;
  logic [BIN_W-1:0]    col_r, col_nxt;
  logic                dbl_r, dbl_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [CNT_W-1:0]    rc_r, rc_nxt;
  logic [PROD_W-1:0]   num_r, num_nxt;
  logic [PROD_W-1:0]   den_r, den_nxt;
  logic                zero_r, zero_nxt;
  logic [PROB_W-1:0]   res_prob_r, res_prob_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PROB_W-1:0]   out_prob_r, out_prob_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_load;

  logic                ram_wr_en;
  logic [BIN_W-1:0]    ram_wr_addr;
  logic [CNT_W-1:0]    ram_wr_data;
  logic                ram_rd_en;
  logic [BIN_W-1:0]    ram_rd_addr;
  logic [CNT_W-1:0]    ram_rd_data;
  logic [CNT_W-1:0]    cnt_masked;

  logic                div_start;
  div_req_t            div_req;
  logic                div_done;
  logic [PROB_W-1:0]   div_quo;

  bpp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_counts (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign div_req = '{num: num_r, den: den_r, dbl: dbl_r};

  bpp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  // A bin that was never written since reset holds a zero count.
  assign cnt_masked = rd_valid_r ? ram_rd_data : '0;

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    rd_valid_nxt   = rd_valid_r;
    bin_nxt        = bin_r;
    col_nxt        = col_r;
    dbl_nxt        = dbl_r;
    total_nxt      = total_r;
    rc_nxt         = rc_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    zero_nxt       = zero_r;
    res_prob_nxt   = res_prob_r;
    res_status_nxt = res_status_r;
    q_pop          = 1'b0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = q_head.row;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = bin_r;
    ram_wr_data    = sat_inc(cnt_masked);
    div_start      = 1'b0;
    out_load       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          bin_nxt = q_head.row;
          col_nxt = q_head.col;
          dbl_nxt = q_head.row != q_head.col;
          if (!q_head.is_query) begin
            ram_rd_en    = 1'b1;
            rd_valid_nxt = valid_r[q_head.row];
            state_nxt    = S_ADD_WR;
          end else if (q_head.bad) begin
            res_prob_nxt   = '0;
            res_status_nxt = ST_BAD_INDEX;
            state_nxt      = S_EMIT;
          end else if (total_r == '0) begin
            res_prob_nxt   = '0;
            res_status_nxt = ST_EMPTY;
            state_nxt      = S_EMIT;
          end else begin
            ram_rd_en    = 1'b1;
            rd_valid_nxt = valid_r[q_head.row];
            state_nxt    = S_Q_COL;
          end
        end
      end
      S_ADD_WR: begin
        ram_wr_en          = 1'b1;
        valid_nxt[bin_r]   = 1'b1;
        total_nxt          = sat_inc(total_r);
        state_nxt          = S_IDLE;
      end
      S_Q_COL: begin
        rc_nxt       = cnt_masked;
        ram_rd_en    = 1'b1;
        ram_rd_addr  = col_r;
        rd_valid_nxt = valid_r[col_r];
        den_nxt      = PROD_W'(total_r) * PROD_W'(total_r);
        state_nxt    = S_Q_MUL;
      end
      S_Q_MUL: begin
        num_nxt   = PROD_W'(rc_r) * PROD_W'(cnt_masked);
        zero_nxt  = (rc_r == '0) || (cnt_masked == '0);
        state_nxt = S_Q_START;
      end
      S_Q_START: begin
        if (zero_r) begin
          res_prob_nxt   = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_Q_DIV;
        end
      end
      S_Q_DIV: begin
        if (div_done) begin
          res_prob_nxt   = div_quo;
          res_status_nxt = ST_OK;
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_load | (out_valid_r & out_stall);
    out_prob_nxt   = out_load ? res_prob_r : out_prob_r;
    out_status_nxt = out_load ? res_status_r : out_status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_valid_r   <= rd_valid_nxt;
    bin_r        <= bin_nxt;
    col_r        <= col_nxt;
    dbl_r        <= dbl_nxt;
    rc_r         <= rc_nxt;
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    zero_r       <= zero_nxt;
    res_prob_r   <= res_prob_nxt;
    res_status_r <= res_status_nxt;
    out_prob_r   <= out_prob_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_prob   = out_prob_r;
  assign out_status = out_status_r;

endmodule

[rtl/core/bpp_queue.sv]
// Short FIFO of classified transactions between the front and back ends.
// Depends on bpp_pkg.
`timescale 1ns / 1ps

module bpp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bpp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output bpp_pkg::item_t head
);
  import bpp_pkg::*;

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = count_r == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/core/bpp_front.sv]
// Front end: takes input transactions, bins add samples, range-checks and
// orders query pairs, and pushes the result to the queue. Depends on bpp_pkg.
`timescale 1ns / 1ps

module bpp_front (
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic [bpp_pkg::EFF_W-1:0]  in_eff_value,
  input  logic [bpp_pkg::LEN_W-1:0]  in_seq_length,
  input  logic [bpp_pkg::IDX_W-1:0]  in_row_bin,
  input  logic [bpp_pkg::IDX_W-1:0]  in_col_bin,
  output logic                       push,
  output bpp_pkg::item_t             push_item,
  input  logic                       q_full
);
  import bpp_pkg::*;

  logic [IDX_W-1:0] hi_idx;
  logic [IDX_W-1:0] lo_idx;

  // The pair value is symmetric, so the larger index always goes to the row.
  assign hi_idx = (in_col_bin > in_row_bin) ? in_col_bin : in_row_bin;
  assign lo_idx = (in_col_bin > in_row_bin) ? in_row_bin : in_col_bin;

  always_comb begin
    push_item.is_query = in_kind == KIND_QUERY;
    if (in_kind == KIND_QUERY) begin
      push_item.bad = (int'(in_row_bin) >= NUM_BINS) || (int'(in_col_bin) >= NUM_BINS);
      push_item.row = BIN_W'(hi_idx);
      push_item.col = BIN_W'(lo_idx);
    end else begin
      push_item.bad = 1'b0;
      push_item.row = bin_of(in_eff_value, in_seq_length);
      push_item.col = '0;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

[rtl/core/binned_pair_probability_core.sv]
// Binned pair probability core: add transactions count a sample into one of
// 42 effective-value/length bins; query transactions return the probability of
// an unordered bin pair as unsigned Q1.31 with a status code. An add passes
// through the back end as a counter read, then a write. A query does two
// counter reads, a multiply step, then the fraction divider, which produces
// one quotient bit per cycle (32 for distinct bins, 31 for a diagonal bin),
// then the output load. Queries that fail the index check or meet an empty
// histogram skip the counter reads and the divider. A two-entry queue lets
// the input side accept transactions while the back end is busy.
`timescale 1ns / 1ps

module binned_pair_probability_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [bpp_pkg::EFF_W-1:0]     in_eff_value,
  input  logic [bpp_pkg::LEN_W-1:0]     in_seq_length,
  input  logic [bpp_pkg::IDX_W-1:0]     in_row_bin,
  input  logic [bpp_pkg::IDX_W-1:0]     in_col_bin,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bpp_pkg::PROB_W-1:0]    out_prob,
  output logic [bpp_pkg::STATUS_W-1:0]  out_status
);
  import bpp_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_valid;
  item_t q_head;
  logic  q_pop;

  bpp_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_eff_value  (in_eff_value),
    .in_seq_length (in_seq_length),
    .in_row_bin    (in_row_bin),
    .in_col_bin    (in_col_bin),
    .push          (push),
    .push_item     (push_item),
    .q_full        (q_full)
  );

  bpp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  bpp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_prob   (out_prob),
    .out_status (out_status)
  );

endmodule

[rtl/core/bpp_checker.sv]
// Port-level checker for the binned pair probability core, with its bind.
// Depends on bpp_pkg and binned_pair_probability_core_assert.svh.
`timescale 1ns / 1ps

`include "binned_pair_probability_core_assert.svh"

module bpp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [bpp_pkg::PROB_W-1:0]    out_prob,
  input logic [bpp_pkg::STATUS_W-1:0]  out_status
);
  import bpp_pkg::*;

  // A stalled result transaction stays and keeps its payload.
  `BPP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_prob) && $stable(out_status), "stalled result changed")

  // Probabilities never exceed 1.0.
  `BPP_ASSERT_IMPLY(a_prob_range, out_valid, out_prob <= PROB_ONE, "probability above one")

  // Error results always carry a zero probability.
  `BPP_ASSERT_IMPLY(a_err_zero, out_valid && (out_status != ST_OK), out_prob == '0, "error result with nonzero probability")

endmodule

bind binned_pair_probability_core bpp_checker u_bpp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_prob   (out_prob),
  .out_status (out_status)
);

[tb/bpp_pair_checker.sv]
// Checker for the binned pair probability core: watches both channels, keeps its
// own bin histogram, predicts each query result and compares it with the block.
// Depends on bpp_pkg for sizes, the kind codes and the status codes.
`timescale 1ns / 1ps

module bpp_pair_checker
  import bpp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_kind,
  input  logic [EFF_W-1:0]    in_eff_value,
  input  logic [LEN_W-1:0]    in_seq_length,
  input  logic [IDX_W-1:0]    in_row_bin,
  input  logic [IDX_W-1:0]    in_col_bin,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [PROB_W-1:0]   out_prob,
  input  logic [STATUS_W-1:0] out_status,
  output int                  mismatches,
  output int                  pending
);

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    status_t           status;
  } pair_result_t;

  localparam int LEN_STEPS [NUM_LEN_LEVELS-1] = '{75, 150, 300, 500, 700};

  logic [CNT_W-1:0] bin_tally [NUM_BINS];
  logic [CNT_W-1:0] sample_total;
  pair_result_t     expected_probs [$];
  pair_result_t     oldest;
  int               error_count;

  function automatic int sample_bin(input logic [EFF_W-1:0] eff,
                                    input logic [LEN_W-1:0] len);
    int eff_lvl;
    int len_lvl;
    eff_lvl = 0;
    len_lvl = 0;
    // Effective thresholds sit at the odd midpoints 3, 5, ... in units of 1/16.
    for (int k = 0; k < NUM_EFF_LEVELS - 1; k++) begin
      if (int'(eff) >= (2 * k + 3) * 16) eff_lvl++;
    end
    for (int k = 0; k < NUM_LEN_LEVELS - 1; k++) begin
      if (int'(len) >= LEN_STEPS[k]) len_lvl++;
    end
    return eff_lvl * NUM_LEN_LEVELS + len_lvl;
  endfunction

  function automatic pair_result_t pair_probability(input logic [IDX_W-1:0] a,
                                                    input logic [IDX_W-1:0] b);
    pair_result_t     r;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] lo;
    logic [127:0]     quot;
    r.prob   = '0;
    r.status = ST_OK;
    if (a >= NUM_BINS || b >= NUM_BINS) begin
      r.status = ST_BAD_INDEX;
    end else if (sample_total == '0) begin
      r.status = ST_EMPTY;
    end else begin
      hi = (a >= b) ? a : b;
      lo = (a >= b) ? b : a;
      if (bin_tally[hi] != '0 && bin_tally[lo] != '0) begin
        // Off-diagonal pairs count twice, hence one more fraction bit.
        quot = (128'(64'(bin_tally[hi]) * 64'(bin_tally[lo]))) << ((hi != lo) ? 32 : 31);
        quot = quot / 128'(64'(sample_total) * 64'(sample_total));
        r.prob = (quot > 128'(PROB_ONE)) ? PROB_ONE : quot[PROB_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (bin_tally[i]) bin_tally[i] = '0;
      sample_total = '0;
      expected_probs.delete();
      error_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_probs.size() == 0) begin
          $display("%0t: unexpected result prob %h status %0d", $time, out_prob, out_status);
          error_count++;
        end else begin
          oldest = expected_probs.pop_front();
          if (out_prob !== oldest.prob) begin
            $display("%0t: prob expected %h actual %h", $time, oldest.prob, out_prob);
            error_count++;
          end
          if (out_status !== oldest.status) begin
            $display("%0t: status expected %0d actual %0d", $time, oldest.status, out_status);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_kind == KIND_ADD) begin
          int b;
          b = sample_bin(in_eff_value, in_seq_length);
          if (bin_tally[b] != '1) bin_tally[b]++;
          if (sample_total != '1) sample_total++;
        end else begin
          expected_probs.push_back(pair_probability(in_row_bin, in_col_bin));
        end
      end
    end
    mismatches <= error_count;
    pending    <= expected_probs.size();
  end

endmodule

[tb/tb_top.sv]
// Top of the binned pair probability core testbench: clock, reset, stimulus and
// verdict. Depends on bpp_pkg, the core and bpp_pair_checker.
`timescale 1ns / 1ps

module tb_top;
  import bpp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 480;
  localparam int DRAIN_CYCLES = 64;

  logic                clk;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic                in_kind       = KIND_ADD;
  logic [EFF_W-1:0]    in_eff_value  = '0;
  logic [LEN_W-1:0]    in_seq_length = '0;
  logic [IDX_W-1:0]    in_row_bin    = '0;
  logic [IDX_W-1:0]    in_col_bin    = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [PROB_W-1:0]   out_prob;
  logic [STATUS_W-1:0] out_status;
  logic                steady        = 1'b0;
  int                  mismatches;
  int                  pending;
  int                  cycles        = 0;

  binned_pair_probability_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_eff_value  (in_eff_value),
    .in_seq_length (in_seq_length),
    .in_row_bin    (in_row_bin),
    .in_col_bin    (in_col_bin),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_prob      (out_prob),
    .out_status    (out_status)
  );

  bpp_pair_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_eff_value  (in_eff_value),
    .in_seq_length (in_seq_length),
    .in_row_bin    (in_row_bin),
    .in_col_bin    (in_col_bin),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_prob      (out_prob),
    .out_status    (out_status),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side stalls with probability 7/100, except during the steady stretch.
  always @(posedge clk) begin
    out_stall <= rst_n && !steady && ($urandom_range(0, 99) < 7);
  end

  task automatic send_item(input logic kind, input logic [EFF_W-1:0] eff,
                           input logic [LEN_W-1:0] len,
                           input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 7) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_eff_value  <= eff;
    in_seq_length <= len;
    in_row_bin    <= row;
    in_col_bin    <= col;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic add_sample(input int eff, input int len);
    send_item(KIND_ADD, EFF_W'(eff), LEN_W'(len), IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic query_pair(input int row, input int col);
    send_item(KIND_QUERY, EFF_W'($urandom), LEN_W'($urandom), IDX_W'(row), IDX_W'(col));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Histogram still empty; a bad index wins over the empty check.
    query_pair(0, 0);
    query_pair(42, 0);
    query_pair(0, 42);
    query_pair(63, 63);
    // Field extremes and both sides of the first and last thresholds.
    add_sample(0, 0);
    add_sample(1023, 65535);
    add_sample(47, 74);
    add_sample(48, 75);
    add_sample(207, 699);
    add_sample(208, 700);
    add_sample(80, 300);
    add_sample(0, 0);
    // Diagonal, off-diagonal in both orders, pairs with an empty bin and a bad index.
    query_pair(0, 0);
    query_pair(41, 0);
    query_pair(0, 41);
    query_pair(7, 0);
    query_pair(0, 7);
    query_pair(5, 0);
    query_pair(41, 41);
    query_pair(63, 0);
    query_pair(14, 14);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= 100 && n < 200);
      if (n == 300) drain_results();
      if ($urandom_range(0, 99) < 60) begin
        // Bias toward the threshold region so that every bin fills up.
        add_sample(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 239),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 799));
      end else begin
        query_pair(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 41),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 41));
      end
    end
    steady <= 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
